FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bpbe_pkg.sv
`default_nettype none
package bpbe_pkg;

   localparam int TOKEN_BITS_DEF = 20;
   localparam int TPB_W          = 11;
   localparam int STRIDE_W       = 10;
   localparam int TAIL_W         = 8;
   localparam int RESERVE_W      = 8;
   localparam int BATCH_W        = 10;
   localparam int PEAK_W         = 32;
   localparam int CSR_DATA_W     = 11;
   localparam int CSR_IDX_W      = 2;
   localparam int MIN_RETAIN     = 2;

   localparam logic [TPB_W-1:0]    TPB_RESET    = 11'd16;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 10'd1;
   localparam logic [TAIL_W-1:0]   TAIL_RESET   = 8'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TPB    = 2'd0,
      CSR_STRIDE = 2'd1,
      CSR_TAIL   = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic adv;
      logic valid;
   } div_ctl_type;

endpackage
`default_nettype wire

FILE: sv/bpbe_chan_if.sv
`default_nettype none
interface bpbe_req_if #(
   parameter int TOKEN_BITS = bpbe_pkg::TOKEN_BITS_DEF
) ();
   import bpbe_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TOKEN_BITS-1:0] seq_tokens;
   logic [TOKEN_BITS-1:0] shared_prefix_tokens;
   logic [TOKEN_BITS-1:0] tokens_to_come;
   logic [RESERVE_W-1:0]  reserve_count;
   logic                  reuse_on;
   logic [BATCH_W-1:0]    batch_count;

   modport source (output valid, seq_tokens, shared_prefix_tokens, tokens_to_come,
                   reserve_count, reuse_on, batch_count, input ready);
   modport sink (input valid, seq_tokens, shared_prefix_tokens, tokens_to_come,
                 reserve_count, reuse_on, batch_count, output ready);
endinterface

interface bpbe_rsp_if ();
   import bpbe_pkg::*;

   logic              valid;
   logic              ready;
   logic [PEAK_W-1:0] peak_need;

   modport source (output valid, peak_need, input ready);
   modport sink (input valid, peak_need, output ready);
endinterface
`default_nettype wire

FILE: sv/batch_peak_block_estimate_core.sv
`default_nettype none
// Peak cache-block estimate for a batch sharing a prefix. Takes one query per cycle unless
// the pipeline is held, and returns one result per query in order. The pipeline is built
// from two bit-per-stage divider pipelines: TOKEN_BITS+1 stages for the ceiling division by
// tokens_per_block and TOKEN_BITS+2 stages for the nine divisions by reuse_stride, plus nine
// stages of add, multiply and saturate. The whole pipeline holds while a finished result
// waits on rsp_chan. Registers must be written through the csr port only while no query is
// in flight; the block itself does not enforce this.
module batch_peak_block_estimate_core #(
   parameter int TOKEN_BITS = bpbe_pkg::TOKEN_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   bpbe_req_if.sink                       req_chan,
   bpbe_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_en,
   input  logic [bpbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpbe_pkg::CSR_DATA_W-1:0] csr_data
);
   import bpbe_pkg::*;
`include "assert_macros.svh"

   localparam int SW = TOKEN_BITS + 1;
   localparam int DW = TOKEN_BITS + 2;
   localparam int LW = DW + 2;
   localparam int MW = BATCH_W + DW + 2;
   localparam int PW = (DW + 14 > PEAK_W + 2) ? DW + 14 : PEAK_W + 2;

   localparam int L_TB  = 0;
   localparam int L_BB  = 1;
   localparam int L_CS  = 2;
   localparam int L_MSC = 3;
   localparam int L_ACT = 4;
   localparam int L_E1  = 5;
   localparam int L_E2  = 6;
   localparam int L_E3  = 7;
   localparam int L_E4  = 8;

   typedef struct packed {
      logic [RESERVE_W-1:0] reserve;
      logic                 reuse;
      logic [BATCH_W-1:0]   batch;
   } a_side_type;

   typedef struct packed {
      logic [3:0][DW-1:0] n;
      logic [DW-1:0]      growth;
      logic [DW-1:0]      pres;
      logic [DW-1:0]      cbase;
      logic [DW-1:0]      pbase;
      logic               reuse;
      logic [BATCH_W-1:0] batch;
   } d_side_type;

   function automatic logic [DW-1:0] span_end(input logic [DW-1:0] x,
                                               input logic [DW-1:0] lim,
                                               input logic [DW-1:0] lo);
      logic [DW-1:0] t;
      t = (x < lim) ? x : lim;
      return (t > lo) ? t : lo;
   endfunction

   // configuration
   logic [TPB_W-1:0]    tpb_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [TAIL_W-1:0]   tail_ff;
   logic [TPB_W-1:0]    bs_eff;
   logic [STRIDE_W-1:0] st_eff;
   logic [TAIL_W-1:0]   m_eff;
   logic [TAIL_W-1:0]   r_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff    <= TPB_RESET;
         stride_ff <= STRIDE_RESET;
         tail_ff   <= TAIL_RESET;
      end else if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_TPB:    tpb_ff    <= csr_data[TPB_W-1:0];
            CSR_STRIDE: stride_ff <= csr_data[STRIDE_W-1:0];
            CSR_TAIL:   tail_ff   <= csr_data[TAIL_W-1:0];
            default:    ;
         endcase
      end
   end

   assign bs_eff = (tpb_ff == '0) ? TPB_W'(1) : tpb_ff;
   assign st_eff = (stride_ff == '0) ? STRIDE_W'(1) : stride_ff;
   assign m_eff  = (tail_ff == '0) ? TAIL_W'(1) : tail_ff;
   assign r_eff  = (m_eff < TAIL_W'(MIN_RETAIN)) ? TAIL_W'(MIN_RETAIN) : m_eff;

   // global advance: every stage moves unless a result is held
   logic        adv;
   logic        out_v_ff;
   div_ctl_type a_ctl;
   div_ctl_type d_ctl;

   assign adv            = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // slot counts: ceiling division by tokens_per_block
   logic [2:0][SW-1:0] a_num;
   a_side_type         a_side_in;
   logic [$bits(a_side_type)-1:0] a_side_raw;
   a_side_type         a_side;
   logic               a_v;
   logic [2:0][SW-1:0] a_quot;
   logic [2:0]         a_nz;

   assign a_num[0] = SW'(req_chan.shared_prefix_tokens);
   assign a_num[1] = SW'(req_chan.seq_tokens);
   assign a_num[2] = SW'(req_chan.seq_tokens) + SW'(req_chan.tokens_to_come);
   assign a_side_in.reserve = req_chan.reserve_count;
   assign a_side_in.reuse   = req_chan.reuse_on;
   assign a_side_in.batch   = (req_chan.batch_count == '0) ? BATCH_W'(1)
                                                           : req_chan.batch_count;
   assign a_ctl.adv   = adv;
   assign a_ctl.valid = req_chan.valid;

   bpbe_div_pipe #(
      .LANES (3),
      .NUM_W (SW),
      .DEN_W (TPB_W),
      .SIDE_W($bits(a_side_type))
   ) u_div_slots (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (a_ctl),
      .num_data (a_num),
      .den_data (bs_eff),
      .side_data(a_side_in),
      .valid_out(a_v),
      .quot_data(a_quot),
      .rem_nz   (a_nz),
      .side_out (a_side_raw)
   );

   assign a_side = a_side_type'(a_side_raw);

   // stage b: round up
   logic                 b_v_ff;
   logic [SW-1:0]        b_cs_ff, b_ss_ff, b_fs_ff;
   logic [SW-1:0]        b_cs_in, b_ss_in, b_fs_in;
   logic [RESERVE_W-1:0] b_rs_ff, b_rs_in, b_reserve_ff;
   logic                 b_reuse_ff;
   logic [BATCH_W-1:0]   b_batch_ff;

   assign b_cs_in = a_quot[0] + SW'(a_nz[0]);
   assign b_ss_in = a_quot[1] + SW'(a_nz[1]);
   assign b_fs_in = a_quot[2] + SW'(a_nz[2]);
   assign b_rs_in = (a_side.reserve == '0) ? '0 : a_side.reserve - RESERVE_W'(1);

   // stage c1: spans of the layout
   logic               c1_v_ff;
   logic [DW-1:0]      c1_cs_ff, c1_ss_ff, c1_init_ff, c1_final_ff, c1_act_ff;
   logic [DW-1:0]      c1_tb_ff, c1_bb_ff, c1_msc_ff;
   logic [DW-1:0]      c1_init_in, c1_final_in, c1_act_in, c1_tb_in, c1_bb_in, c1_msc_in;
   logic [DW-1:0]      c1_ssm;
   logic [LW-1:0]      c1_lastp1_ff, c1_lastp1_in;
   logic               c1_reuse_ff;
   logic [BATCH_W-1:0] c1_batch_ff;

   assign c1_init_in  = DW'(b_ss_ff) + DW'(b_rs_ff);
   assign c1_final_in = DW'(b_fs_ff) + DW'(b_rs_ff);
   assign c1_act_in   = (c1_init_in > DW'(b_cs_ff)) ? c1_init_in : DW'(b_cs_ff);
   assign c1_tb_in    = (DW'(b_cs_ff) > DW'(m_eff)) ? DW'(b_cs_ff) - DW'(m_eff) : '0;
   assign c1_ssm      = (DW'(b_ss_ff) > DW'(m_eff)) ? DW'(b_ss_ff) - DW'(m_eff) : '0;
   assign c1_bb_in    = (c1_ssm > DW'(b_cs_ff)) ? c1_ssm : DW'(b_cs_ff);
   assign c1_msc_in   = (b_ss_ff > b_cs_ff) ? DW'(b_ss_ff) : DW'(b_cs_ff);
   // one past the last slot freed before the final append, may go negative
   assign c1_lastp1_in = LW'(b_fs_ff) + LW'(b_rs_ff) - LW'(r_eff) - LW'(b_reserve_ff)
                       - LW'(1);

   // stage c2: growth, freed span ends, dividends for the stride divider
   logic               c2_v_ff;
   logic [8:0][DW-1:0] c2_num_ff, c2_num_in;
   logic [DW-1:0]      c2_growth_ff, c2_pres_ff, c2_cbase_ff, c2_pbase_ff;
   logic [DW-1:0]      c2_growth_in, c2_pres_in, c2_cbase_in, c2_pbase_in;
   logic [DW-1:0]      c2_diff, c2_lim;
   logic               c2_cond;
   logic               c2_reuse_ff;
   logic [BATCH_W-1:0] c2_batch_ff;

   assign c2_diff      = c1_final_ff - c1_act_ff;
   assign c2_growth_in = (c1_final_ff > c1_act_ff) ? c2_diff : '0;
   assign c2_cond      = (c1_final_ff > c1_act_ff) && (c2_diff > DW'(1))
                       && !c1_lastp1_ff[LW-1] && (c1_lastp1_ff != '0);
   assign c2_lim       = c1_lastp1_ff[DW-1:0];
   assign c2_pres_in   = (c1_init_ff > c1_msc_ff) ? c1_init_ff - c1_msc_ff : '0;
   assign c2_cbase_in  = c1_cs_ff - c1_tb_ff;
   assign c2_pbase_in  = (c1_ss_ff > c1_bb_ff) ? c1_ss_ff - c1_bb_ff : '0;

   // an empty span is coded as end equal to begin
   always_comb begin
      c2_num_in[L_TB]  = c1_tb_ff;
      c2_num_in[L_BB]  = c1_bb_ff;
      c2_num_in[L_CS]  = c1_cs_ff;
      c2_num_in[L_MSC] = c1_msc_ff;
      c2_num_in[L_ACT] = c1_act_ff;
      c2_num_in[L_E1]  = c2_cond ? span_end(c1_cs_ff, c2_lim, c1_tb_ff) : c1_tb_ff;
      c2_num_in[L_E2]  = c2_cond ? span_end(c1_ss_ff, c2_lim, c1_bb_ff) : c1_bb_ff;
      c2_num_in[L_E3]  = c2_cond ? span_end(c1_init_ff, c2_lim, c1_msc_ff) : c1_msc_ff;
      c2_num_in[L_E4]  = c2_cond ? span_end(c1_final_ff, c2_lim, c1_act_ff) : c1_act_ff;
   end

   // stride divisions for the stride hit counts
   d_side_type         d_side_in;
   logic [$bits(d_side_type)-1:0] d_side_raw;
   d_side_type         d_side;
   logic               d_v;
   logic [8:0][DW-1:0] d_quot;

   assign d_side_in.n[0]   = c2_num_ff[L_E1] - c2_num_ff[L_TB];
   assign d_side_in.n[1]   = c2_num_ff[L_E2] - c2_num_ff[L_BB];
   assign d_side_in.n[2]   = c2_num_ff[L_E3] - c2_num_ff[L_MSC];
   assign d_side_in.n[3]   = c2_num_ff[L_E4] - c2_num_ff[L_ACT];
   assign d_side_in.growth = c2_growth_ff;
   assign d_side_in.pres   = c2_pres_ff;
   assign d_side_in.cbase  = c2_cbase_ff;
   assign d_side_in.pbase  = c2_pbase_ff;
   assign d_side_in.reuse  = c2_reuse_ff;
   assign d_side_in.batch  = c2_batch_ff;
   assign d_ctl.adv   = adv;
   assign d_ctl.valid = c2_v_ff;

   bpbe_div_pipe #(
      .LANES (9),
      .NUM_W (DW),
      .DEN_W (STRIDE_W),
      .SIDE_W($bits(d_side_type))
   ) u_div_stride (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (d_ctl),
      .num_data (c2_num_ff),
      .den_data (st_eff),
      .side_data(d_side_in),
      .valid_out(d_v),
      .quot_data(d_quot),
      .rem_nz   (),
      .side_out (d_side_raw)
   );

   assign d_side = d_side_type'(d_side_raw);

   // stage e1: materialized counts and stride hits per freed span
   logic               e1_v_ff;
   logic [DW-1:0]      e1_cmat_ff, e1_pmat_ff, e1_cmat_in, e1_pmat_in;
   logic [3:0][DW-1:0] e1_k_ff, e1_k_in, e1_n_ff;
   logic [DW-1:0]      e1_growth_ff, e1_pres_ff;
   logic [BATCH_W-1:0] e1_batch_ff;

   assign e1_cmat_in = d_side.cbase + (d_side.reuse ? d_quot[L_TB] : '0);
   assign e1_pmat_in = d_side.pbase + (d_side.reuse ? d_quot[L_BB] - d_quot[L_CS] : '0);
   assign e1_k_in[0] = d_side.reuse ? d_quot[L_E1] - d_quot[L_TB]  : '0;
   assign e1_k_in[1] = d_side.reuse ? d_quot[L_E2] - d_quot[L_BB]  : '0;
   assign e1_k_in[2] = d_side.reuse ? d_quot[L_E3] - d_quot[L_MSC] : '0;
   assign e1_k_in[3] = d_side.reuse ? d_quot[L_E4] - d_quot[L_ACT] : '0;

   // stage e2: freed per span
   logic               e2_v_ff;
   logic [3:0][DW-1:0] e2_f_ff, e2_f_in;
   logic [DW:0]        e2_pp_ff, e2_pp_in;
   logic [DW-1:0]      e2_cmat_ff, e2_growth_ff;
   logic [BATCH_W-1:0] e2_batch_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         e2_f_in[i] = e1_n_ff[i] - e1_k_ff[i];
      end
   end
   assign e2_pp_in = (DW+1)'(e1_pmat_ff) + (DW+1)'(e1_pres_ff);

   // stage e3: per-sequence freed total
   logic               e3_v_ff;
   logic [DW+1:0]      e3_fsum_ff, e3_fsum_in;
   logic [DW-1:0]      e3_f1_ff, e3_cmat_ff, e3_growth_ff;
   logic [DW:0]        e3_pp_ff;
   logic [BATCH_W-1:0] e3_batch_ff;

   assign e3_fsum_in = (DW+2)'(e2_f_ff[1]) + (DW+2)'(e2_f_ff[2]) + (DW+2)'(e2_f_ff[3]);

   // stage m: scale by batch
   logic               m_v_ff;
   logic [MW-1:0]      m_bpp_ff, m_bfs_ff, m_bgr_ff, m_bpp_in, m_bfs_in, m_bgr_in;
   logic [DW-1:0]      m_cmat_ff, m_f1_ff;
   logic               m_grow_ff;
   logic [BATCH_W-1:0] m_batch_ff;

   assign m_bpp_in = e3_batch_ff * (DW+2)'(e3_pp_ff);
   assign m_bfs_in = e3_batch_ff * e3_fsum_ff;
   assign m_bgr_in = e3_batch_ff * (DW+2)'(e3_growth_ff);

   // stage f1: initial count and net growth
   logic               f1_v_ff;
   logic [PW-1:0]      f1_init_ff, f1_net_ff, f1_init_in, f1_net_in;
   logic               f1_grow_ff;
   logic [BATCH_W-1:0] f1_batch_ff;

   assign f1_init_in = PW'(m_cmat_ff) + PW'(m_bpp_ff);
   assign f1_net_in  = PW'(m_bgr_ff) - PW'(m_f1_ff) - PW'(m_bfs_ff);

   // output stage: floor at initial plus batch, saturate
   logic [PEAK_W-1:0]  out_peak_ff, out_peak_in;
   logic [PW-1:0]      o_tot, o_flo, o_sel, o_pk;

   assign o_tot = f1_init_ff + f1_net_ff;
   assign o_flo = f1_init_ff + PW'(f1_batch_ff);
   assign o_sel = ($signed(o_tot) > $signed(o_flo)) ? o_tot : o_flo;
   assign o_pk  = f1_grow_ff ? o_sel : f1_init_ff;

   always_comb begin
      if (o_pk[PW-1]) begin
         out_peak_in = '0;
      end else if (o_pk > PW'({PEAK_W{1'b1}})) begin
         out_peak_in = {PEAK_W{1'b1}};
      end else begin
         out_peak_in = o_pk[PEAK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff   <= 1'b0;
         c1_v_ff  <= 1'b0;
         c2_v_ff  <= 1'b0;
         e1_v_ff  <= 1'b0;
         e2_v_ff  <= 1'b0;
         e3_v_ff  <= 1'b0;
         m_v_ff   <= 1'b0;
         f1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff   <= a_v;
         c1_v_ff  <= b_v_ff;
         c2_v_ff  <= c1_v_ff;
         e1_v_ff  <= d_v;
         e2_v_ff  <= e1_v_ff;
         e3_v_ff  <= e2_v_ff;
         m_v_ff   <= e3_v_ff;
         f1_v_ff  <= m_v_ff;
         out_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_cs_ff      <= b_cs_in;
         b_ss_ff      <= b_ss_in;
         b_fs_ff      <= b_fs_in;
         b_rs_ff      <= b_rs_in;
         b_reserve_ff <= a_side.reserve;
         b_reuse_ff   <= a_side.reuse;
         b_batch_ff   <= a_side.batch;

         c1_cs_ff     <= DW'(b_cs_ff);
         c1_ss_ff     <= DW'(b_ss_ff);
         c1_init_ff   <= c1_init_in;
         c1_final_ff  <= c1_final_in;
         c1_act_ff    <= c1_act_in;
         c1_tb_ff     <= c1_tb_in;
         c1_bb_ff     <= c1_bb_in;
         c1_msc_ff    <= c1_msc_in;
         c1_lastp1_ff <= c1_lastp1_in;
         c1_reuse_ff  <= b_reuse_ff;
         c1_batch_ff  <= b_batch_ff;

         c2_num_ff    <= c2_num_in;
         c2_growth_ff <= c2_growth_in;
         c2_pres_ff   <= c2_pres_in;
         c2_cbase_ff  <= c2_cbase_in;
         c2_pbase_ff  <= c2_pbase_in;
         c2_reuse_ff  <= c1_reuse_ff;
         c2_batch_ff  <= c1_batch_ff;

         e1_cmat_ff   <= e1_cmat_in;
         e1_pmat_ff   <= e1_pmat_in;
         e1_k_ff      <= e1_k_in;
         e1_n_ff      <= d_side.n;
         e1_growth_ff <= d_side.growth;
         e1_pres_ff   <= d_side.pres;
         e1_batch_ff  <= d_side.batch;

         e2_f_ff      <= e2_f_in;
         e2_pp_ff     <= e2_pp_in;
         e2_cmat_ff   <= e1_cmat_ff;
         e2_growth_ff <= e1_growth_ff;
         e2_batch_ff  <= e1_batch_ff;

         e3_fsum_ff   <= e3_fsum_in;
         e3_f1_ff     <= e2_f_ff[0];
         e3_pp_ff     <= e2_pp_ff;
         e3_cmat_ff   <= e2_cmat_ff;
         e3_growth_ff <= e2_growth_ff;
         e3_batch_ff  <= e2_batch_ff;

         m_bpp_ff     <= m_bpp_in;
         m_bfs_ff     <= m_bfs_in;
         m_bgr_ff     <= m_bgr_in;
         m_cmat_ff    <= e3_cmat_ff;
         m_f1_ff      <= e3_f1_ff;
         m_grow_ff    <= (e3_growth_ff != '0);
         m_batch_ff   <= e3_batch_ff;

         f1_init_ff   <= f1_init_in;
         f1_net_ff    <= f1_net_in;
         f1_grow_ff   <= m_grow_ff;
         f1_batch_ff  <= m_batch_ff;

         out_peak_ff  <= out_peak_in;
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.peak_need = out_peak_ff;

   `ASSERT_ALWAYS(a_reset_flushes, clock, reset |=> !out_v_ff && !e1_v_ff && !c2_v_ff,
      "pipeline valid bits not cleared by reset")
   `ASSERT_CLK(a_unknown_csr_ignored, clock, reset,
      csr_write_en && csr_index != CSR_TPB && csr_index != CSR_STRIDE &&
      csr_index != CSR_TAIL |=> $stable(tpb_ff) && $stable(stride_ff) && $stable(tail_ff),
      "write to an unknown register changed the configuration")
   `ASSERT_CLK(a_stall_freezes, clock, reset,
      !adv |=> $stable(c1_v_ff) && $stable(e3_v_ff) && $stable(f1_v_ff) && out_v_ff,
      "pipeline moved while a result was held")

endmodule
`default_nettype wire

FILE: sv/bpbe_div_pipe.sv
`default_nettype none
module bpbe_div_pipe #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bpbe_pkg::div_ctl_type         ctl_in,
   input  logic [LANES-1:0][NUM_W-1:0]   num_data,
   input  logic [DEN_W-1:0]              den_data,
   input  logic [SIDE_W-1:0]             side_data,
   output logic                          valid_out,
   output logic [LANES-1:0][NUM_W-1:0]   quot_data,
   output logic [LANES-1:0]              rem_nz,
   output logic [SIDE_W-1:0]             side_out
);
   import bpbe_pkg::*;

   // one quotient bit per stage, restoring form, msb first
   logic                          valid_ff [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]   num_ff   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]   rem_ff   [NUM_W];
   logic [DEN_W-1:0]              den_ff   [NUM_W];
   logic [SIDE_W-1:0]             side_ff  [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]   num_in   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]   rem_in   [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic                        v_src;
      logic [LANES-1:0][NUM_W-1:0] num_src;
      logic [LANES-1:0][DEN_W-1:0] rem_src;
      logic [DEN_W-1:0]            den_src;
      logic [SIDE_W-1:0]           side_src;
      logic [LANES-1:0][DEN_W:0]   trial;
      logic [LANES-1:0][DEN_W:0]   diff;

      if (s == 0) begin : g_first
         assign v_src    = ctl_in.valid;
         assign num_src  = num_data;
         assign rem_src  = '0;
         assign den_src  = den_data;
         assign side_src = side_data;
      end else begin : g_next
         assign v_src    = valid_ff[s-1];
         assign num_src  = num_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l]     = {rem_src[l], num_src[l][NUM_W-1]};
            diff[l]      = trial[l] - {1'b0, den_src};
            if (trial[l] >= {1'b0, den_src}) begin
               rem_in[s][l] = diff[l][DEN_W-1:0];
               num_in[s][l] = {num_src[l][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[s][l] = trial[l][DEN_W-1:0];
               num_in[s][l] = {num_src[l][NUM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ctl_in.adv) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.adv) begin
            num_ff[s]  <= num_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign valid_out = valid_ff[NUM_W-1];
   assign quot_data = num_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rem_nz[l] = |rem_ff[NUM_W-1][l];
      end
   end

endmodule
`default_nettype wire

FILE: verif/batch_peak_block_estimate_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module batch_peak_block_estimate_core_tb;
   import bpbe_pkg::*;

   localparam int TB_TOKEN_BITS = TOKEN_BITS_DEF;
   localparam int PIPE_LAT      = 2 * TB_TOKEN_BITS + 12;
   localparam int IDLE_LIMIT    = 20000;
   localparam int N_RANDOM      = 2000;

   typedef logic [TB_TOKEN_BITS-1:0] tok_t;

   typedef struct {
      tok_t                 seq_tokens;
      tok_t                 prefix_tokens;
      tok_t                 to_come;
      logic [RESERVE_W-1:0] reserve;
      logic                 reuse;
      logic [BATCH_W-1:0]   batch;
   } query_t;

   typedef struct {
      query_t      q;
      logic        fixed;
      logic [31:0] peak;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_TPB;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   bpbe_req_if #(.TOKEN_BITS(TB_TOKEN_BITS)) req_chan ();
   bpbe_rsp_if rsp_chan ();

   batch_peak_block_estimate_core #(.TOKEN_BITS(TB_TOKEN_BITS)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan.sink),
      .rsp_chan     (rsp_chan.source),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the block's registers
   logic [TPB_W-1:0]    cur_tpb    = TPB_RESET;
   logic [STRIDE_W-1:0] cur_stride = STRIDE_RESET;
   logic [TAIL_W-1:0]   cur_tail   = TAIL_RESET;

   logic [31:0] peak_queue[$];
   int          fail_count = 0;
   int          idle_cycles = 0;

   function automatic longint hits(longint b, longint e, longint s);
      if (b < 0) b = 0;
      if (e < b) e = b;
      return e / s - b / s;
   endfunction

   function automatic longint freed_slots(longint b, longint e, bit ru, longint s);
      if (b < 0) b = 0;
      if (e < b) e = b;
      return ru ? (e - b) - hits(b, e, s) : (e - b);
   endfunction

   function automatic longint lmax(longint a, longint b);
      return a > b ? a : b;
   endfunction

   function automatic longint lmin(longint a, longint b);
      return a < b ? a : b;
   endfunction

   function automatic longint live_slots(longint b, longint e, longint slots, longint m,
                                         bit ru, longint s);
      longint tb, te;
      b = lmax(b, 0);
      e = lmax(e, b);
      if (e <= b || slots <= 0) return 0;
      tb = lmax(0, slots - m);
      te = lmin(e, slots);
      if (ru) return hits(b, e, s) + freed_slots(lmax(b, tb), te, 1'b1, s);
      return lmax(0, te - lmax(b, tb));
   endfunction

   function automatic logic [31:0] predict_peak(query_t q);
      longint bs, st, m, r, batch, rsv, cs, ss, fs, rs, init_s, final_s, act_init;
      longint growth, initial_n, last, freed, peak;
      bit ru;
      bs = lmax(cur_tpb, 1);
      st = lmax(cur_stride, 1);
      m = lmax(cur_tail, 1);
      r = lmax(MIN_RETAIN, m);
      batch = lmax(q.batch, 1);
      rsv = q.reserve;
      ru = q.reuse;
      cs = (longint'(q.prefix_tokens) + bs - 1) / bs;
      ss = (longint'(q.seq_tokens) + bs - 1) / bs;
      fs = (longint'(q.seq_tokens) + longint'(q.to_come) + bs - 1) / bs;
      rs = rsv > 0 ? rsv - 1 : 0;
      init_s = ss + rs;
      final_s = fs + rs;
      act_init = lmax(init_s, cs);
      growth = lmax(final_s - act_init, 0);
      initial_n = live_slots(0, cs, cs, m, ru, st)
                  + batch * (live_slots(cs, ss, ss, m, ru, st)
                             + lmax(0, init_s - lmax(ss, cs)));
      if (growth == 0) begin
         peak = initial_n;
      end else begin
         last = act_init + growth - r - 2 - rsv;
         freed = 0;
         if (growth > 1 && last >= 0) begin
            freed += freed_slots(lmax(0, cs - m), lmin(cs, last + 1), ru, st);
            freed += batch * freed_slots(lmax(cs, ss - m), lmin(ss, last + 1), ru, st);
            freed += batch * freed_slots(lmax(ss, cs), lmin(init_s, last + 1), ru, st);
            freed += batch * freed_slots(act_init, lmin(act_init + growth, last + 1),
                                         ru, st);
         end
         peak = lmax(initial_n + batch * growth - freed, initial_n + batch);
      end
      if (peak < 0) peak = 0;
      if (peak > 64'hFFFF_FFFF) peak = 64'hFFFF_FFFF;
      return peak[31:0];
   endfunction

   // receiver stall pattern and result check
   logic [3:0] stall_phase = '0;
   logic [1:0] stall_mode  = '0;
   logic [31:0] want;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == 4'hF) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_chan.ready <= 1'b1;
         2'd1: rsp_chan.ready <= stall_phase[0];
         2'd2: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (peak_queue.size() == 0) begin
            $error("peak_need: unexpected transfer, actual %0d", rsp_chan.peak_need);
            fail_count++;
         end else begin
            want = peak_queue.pop_front();
            if (rsp_chan.peak_need !== want) begin
               $error("peak_need: expected %0d actual %0d", want, rsp_chan.peak_need);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("batch_peak_block_estimate_core regression: fail");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.seq_tokens = '0;
      req_chan.shared_prefix_tokens = '0;
      req_chan.tokens_to_come = '0;
      req_chan.reserve_count = '0;
      req_chan.reuse_on = 1'b0;
      req_chan.batch_count = '0;
   end

   int burst_left = 0;

   task automatic send_query(query_t q, logic [31:0] exp_peak);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_chan.valid <= 1'b1;
      req_chan.seq_tokens <= q.seq_tokens;
      req_chan.shared_prefix_tokens <= q.prefix_tokens;
      req_chan.tokens_to_come <= q.to_come;
      req_chan.reserve_count <= q.reserve;
      req_chan.reuse_on <= q.reuse;
      req_chan.batch_count <= q.batch;
      do @(posedge clock); while (!req_chan.ready);
      peak_queue = {peak_queue, exp_peak};
      burst_left--;
   endtask

   task automatic drain_and_idle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (peak_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      @(posedge clock);
      case (idx)
         CSR_TPB:    cur_tpb = TPB_W'(val);
         CSR_STRIDE: cur_stride = STRIDE_W'(val);
         default:    cur_tail = TAIL_W'(val);
      endcase
   endtask

   // skewed token counts: half small, otherwise full range or near the maximum
   function automatic tok_t rand_tokens();
      case ($urandom_range(0, 3))
         0: return tok_t'($urandom_range(0, 64));
         1: return tok_t'($urandom_range(0, 4096));
         2: return tok_t'($urandom);
         default: return tok_t'((1 << TB_TOKEN_BITS) - 1 - $urandom_range(0, 16));
      endcase
   endfunction

   function automatic query_t rand_query();
      query_t q;
      q.seq_tokens = rand_tokens();
      q.prefix_tokens = $urandom_range(0, 1) ? rand_tokens() : q.seq_tokens;
      q.to_come = rand_tokens();
      q.reserve = RESERVE_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4));
      q.reuse = 1'($urandom);
      q.batch = BATCH_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8));
      return q;
   endfunction

   row_t plan[$];
   query_t tq;

   task automatic add_row(int s, int p, int c, int rsv, int ru, int b,
                          logic fx, logic [31:0] pk);
      row_t rw;
      rw.q.seq_tokens = tok_t'(s);
      rw.q.prefix_tokens = tok_t'(p);
      rw.q.to_come = tok_t'(c);
      rw.q.reserve = RESERVE_W'(rsv);
      rw.q.reuse = 1'(ru);
      rw.q.batch = BATCH_W'(b);
      rw.fixed = fx;
      rw.peak = pk;
      plan = {plan, rw};
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero gives nothing; zero batch acts as one
      add_row(0, 0, 0, 0, 0, 0, 1'b1, 32'd0);
      add_row(16, 0, 0, 0, 0, 1, 1'b1, 32'd1);
      add_row(17, 0, 0, 0, 0, 0, 1'b0, '0);
      add_row(-1, -1, -1, 255, 1, 1023, 1'b0, '0);
      add_row(-1, 0, -1, 255, 0, 1023, 1'b0, '0);
      add_row(0, -1, 0, 0, 1, 1023, 1'b0, '0);
      add_row(100, 50, 1000, 3, 1, 4, 1'b0, '0);
      add_row(100, 50, 1000, 3, 0, 4, 1'b0, '0);
      add_row(32, 32, 0, 1, 0, 2, 1'b0, '0);
      add_row(0, 0, 1, 0, 0, 5, 1'b0, '0);
      add_row(1, 200, 5000, 128, 1, 1, 1'b0, '0);
      add_row(20'h55555, 20'hAAAAA, 20'h5A5A5, 8'hAA, 1, 10'h155, 1'b0, '0);
      add_row(20'hAAAAA, 20'h55555, 20'hA5A5A, 8'h55, 0, 10'h2AA, 1'b0, '0);
      foreach (plan[i])
         send_query(plan[i].q, plan[i].fixed ? plan[i].peak : predict_peak(plan[i].q));
      drain_and_idle();

      // zero registers act as one, then extremes, then random settings
      for (k = 0; k < 8; k++) begin
         case (k)
            0: begin
               write_reg(CSR_TPB, 0); write_reg(CSR_STRIDE, 0); write_reg(CSR_TAIL, 0);
            end
            1: begin
               write_reg(CSR_TPB, 1024); write_reg(CSR_STRIDE, 1023);
               write_reg(CSR_TAIL, 255);
            end
            2: begin
               write_reg(CSR_TPB, 1); write_reg(CSR_STRIDE, 2); write_reg(CSR_TAIL, 2);
            end
            3: begin
               write_reg(CSR_TPB, 'h7FF); write_reg(CSR_STRIDE, 'h3FF);
               write_reg(CSR_TAIL, 'hFF);
            end
            default: begin
               write_reg(CSR_TPB, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 64));
               write_reg(CSR_STRIDE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8));
               write_reg(CSR_TAIL, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 6));
            end
         endcase
         csr_write_en <= 1'b0;
         repeat (N_RANDOM / 8) begin
            tq = rand_query();
            send_query(tq, predict_peak(tq));
         end
         drain_and_idle();
      end

      if (fail_count == 0)
         $display("batch_peak_block_estimate_core regression: pass");
      else
         $display("batch_peak_block_estimate_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
+incdir+sv
sv/bpbe_pkg.sv
sv/bpbe_chan_if.sv
sv/bpbe_div_pipe.sv
sv/batch_peak_block_estimate_core.sv
verif/batch_peak_block_estimate_core_tb.sv
